// ----- rtl/core/cyrillic_vigenere_cipher_core_assert.svh -----
// Assertion macros for the cipher core checker.
`ifndef CYRILLIC_VIGENERE_CIPHER_CORE_ASSERT_SVH
`define CYRILLIC_VIGENERE_CIPHER_CORE_ASSERT_SVH

// a implies c in the same cycle; idle in reset
`define CVC_ASSERT_NOW(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("cvc assertion failed");

// a implies c in the next cycle; idle in reset
`define CVC_ASSERT_NEXT(name, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("cvc assertion failed");

// a implies c in the next cycle; also checked through reset
`define CVC_ASSERT_ALWAYS_NEXT(name, a, c) \
  name: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("cvc assertion failed");

`endif

// ----- rtl/core/cvc_pkg.sv -----
`default_nettype none

package cvc_pkg;

  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT_MODE = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_CIPHER  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] key_slot;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_letter;
  } res_t;

  // Cyrillic letters sit in 192..255
  function automatic logic is_letter(input logic [7:0] b);
    return (b[7:6] == 2'b11);
  endfunction

  function automatic logic [4:0] key_shift(input logic [7:0] b);
    return is_letter(b) ? b[4:0] : 5'd0;
  endfunction

  // case block kept in bit 5, letter index wraps modulo 32
  function automatic logic [7:0] shift_letter(input logic [7:0] b,
                                              input logic [4:0] s,
                                              input logic       dec);
    logic [4:0] idx;
    idx = dec ? (b[4:0] - s) : (b[4:0] + s);
    return {b[7:5], idx};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cvc_key_mem.sv -----
`default_nettype none

module cvc_key_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [4:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [4:0]    rdata
);

  logic [4:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/cvc_mod_unit.sv -----
`default_nettype none

// restoring remainder, one dividend bit per cycle
module cvc_mod_unit #(
  parameter int PW = 10,
  parameter int LW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [LW-1:0] divisor,
  output logic               done,
  output logic      [PW-1:0] remainder
);

  localparam int CW = $clog2(PW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [PW-1:0] num;
  logic [PW:0]   trial;
  logic [PW:0]   div_ext;

  assign div_ext = (PW+1)'(divisor);
  assign trial   = {remainder, num[PW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        cnt       <= CW'(PW);
        num       <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (trial >= div_ext) begin
          remainder <= PW'(trial - div_ext);
        end else begin
          remainder <= trial[PW-1:0];
        end
        num <= num << 1;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cyrillic_vigenere_cipher_core.sv -----
// channel  dir  handshake               payload
// req      in   req_valid / req_stall   req_data  (req_t: op, key_slot, data_byte)
// res      out  res_valid / res_stall   res_data  (res_t: out_byte, was_letter)
// cfg      in   cfg_en                  cfg_index, cfg_data
//
// Load and restart requests are done in S_IDLE; a non-letter byte goes to S_DONE.
// A letter goes through S_FETCH and S_CHECK once per key entry read (one entry when
// the next entry is nonzero), each a key store read and a check, then S_DONE.
// A position left beyond a shortened key_length first goes through S_MOD.
// Reset clears control state only; the key store is undefined until loaded.
// A result held by res_stall parks the following cipher request in S_DONE, req_stall high.
`default_nettype none

module cyrillic_vigenere_cipher_core
  import cvc_pkg::*;
#(
  parameter int KEY_DEPTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire req_t                   req_data,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output res_t                        res_data,
  input  wire logic                   cfg_en,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW = $clog2(KEY_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_t;

  state_t          state;
  logic [10:0]     key_length;
  logic            decrypt_mode;
  logic [PW-1:0]   pos;
  logic [LW-1:0]   tries;
  logic [7:0]      text;
  res_t            pend;

  logic [LW-1:0]   eff_len;
  logic [PW-1:0]   pos_wrap;
  logic [PW:0]     pos_inc;
  logic            pos_ge;
  logic            accept;
  logic            mem_we;
  logic [4:0]      mem_rdata;
  logic            mod_start;
  logic            mod_done;
  logic [PW-1:0]   mod_rem;
  logic [LW-1:0]   tries_inc;

  always_comb begin
    if (key_length == 11'd0) begin
      eff_len = LW'(1);
    end else if (32'(key_length) > 32'(KEY_DEPTH)) begin
      eff_len = LW'(KEY_DEPTH);
    end else begin
      eff_len = LW'(key_length);
    end
  end

  assign pos_ge    = (PW+1)'(pos) >= (PW+1)'(eff_len);
  assign pos_inc   = (PW+1)'(pos) + (PW+1)'(1);
  assign pos_wrap  = (pos_inc == (PW+1)'(eff_len)) ? '0 : pos_inc[PW-1:0];
  assign tries_inc = tries + LW'(1);

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign mem_we    = accept && (req_data.op == OP_LOAD)
                     && (32'(req_data.key_slot) < 32'(KEY_DEPTH));
  assign mod_start = accept && (req_data.op == OP_CIPHER)
                     && is_letter(req_data.data_byte) && pos_ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length   <= 11'd1;
      decrypt_mode <= 1'b0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_KEY_LENGTH:   key_length   <= cfg_data;
        CFG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cvc_key_mem #(
    .DEPTH (KEY_DEPTH),
    .AW    (PW)
  ) u_key_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (PW'(req_data.key_slot)),
    .wdata (key_shift(req_data.data_byte)),
    .raddr (pos),
    .rdata (mem_rdata)
  );

  cvc_mod_unit #(
    .PW (PW),
    .LW (LW)
  ) u_mod_unit (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (pos),
    .divisor   (eff_len),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req_data.op)
              OP_RESTART: pos <= '0;
              OP_CIPHER: begin
                text  <= req_data.data_byte;
                tries <= '0;
                if (!is_letter(req_data.data_byte)) begin
                  pend  <= '{out_byte: req_data.data_byte, was_letter: 1'b0};
                  state <= S_DONE;
                end else if (pos_ge) begin
                  state <= S_MOD;
                end else begin
                  state <= S_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            pos   <= mod_rem;
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_CHECK;
        S_CHECK: begin
          pos   <= pos_wrap;
          tries <= tries_inc;
          if (mem_rdata != 5'd0 || tries_inc == eff_len) begin
            pend  <= '{out_byte:   shift_letter(text, mem_rdata, decrypt_mode),
                       was_letter: 1'b1};
            state <= S_DONE;
          end else begin
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res_data  <= pend;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cvc_checker.sv -----
`default_nettype none

`include "cyrillic_vigenere_cipher_core_assert.svh"

module cvc_checker
  import cvc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req_data,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire res_t res_data
);

  `CVC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res_data))
  `CVC_ASSERT_NOW(a_letter_flag, res_valid, res_data.was_letter == is_letter(res_data.out_byte))
  `CVC_ASSERT_ALWAYS_NEXT(a_reset_clear, rst, !res_valid && !req_stall)
  `CVC_ASSERT_NEXT(a_load_single, req_valid && !req_stall && req_data.op == OP_LOAD, !req_stall)

endmodule

bind cyrillic_vigenere_cipher_core cvc_checker u_cvc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_data  (req_data),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

`default_nettype wire

// ----- tb/cvc_checker.sv -----
`timescale 1ns / 100ps

module cvc_tb_checker
  import cvc_pkg::*;
#(
  parameter int KEY_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_stall,
  input  req_t                   req_data,
  input  logic                   res_valid,
  input  logic                   res_stall,
  input  res_t                   res_data,
  input  logic                   cfg_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int unsigned            fails,
  output int unsigned            pending
);

  logic [4:0]            shift_table [KEY_DEPTH];
  int unsigned           key_pos;
  logic [CFG_DATA_W-1:0] key_length;
  logic                  decrypting;
  res_t                  cipher_q [$];

  task automatic flag_error(string what, logic [7:0] got, logic [7:0] want);
    $display("checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $time);
    fails++;
  endtask

  function automatic logic [4:0] shift_of(logic [7:0] b);
    if (b >= 8'd224) return 5'(b - 8'd224);
    if (b >= 8'd192) return 5'(b - 8'd192);
    return 5'd0;
  endfunction

  // walks the key from the current position; moves key_pos as a side effect
  function automatic res_t encipher(logic [7:0] b);
    res_t        r;
    int unsigned len;
    int unsigned pos;
    int unsigned tries;
    logic [4:0]  s;
    logic [4:0]  idx;
    logic [7:0]  base;
    logic        found;
    r.out_byte = b;
    r.was_letter = 1'b0;
    if (b < 8'd192) return r;
    if (key_length == 0) len = 1;
    else if (key_length > KEY_DEPTH) len = KEY_DEPTH;
    else len = key_length;
    pos = key_pos % len;
    s = 5'd0;
    found = 1'b0;
    tries = 0;
    while (!found && tries < len) begin
      s = shift_table[pos];
      pos = (pos + 1 == len) ? 0 : pos + 1;
      found = (s != 5'd0);
      tries++;
    end
    key_pos = pos;
    base = (b >= 8'd224) ? 8'd224 : 8'd192;
    idx = 5'(b - base);
    idx = decrypting ? idx - s : idx + s;
    r.out_byte = base + {3'b000, idx};
    r.was_letter = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin : track
    res_t want;
    if (rst) begin
      fails = 0;
      key_pos = 0;
      key_length = 1;
      decrypting = 1'b0;
      cipher_q.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_KEY_LENGTH:   key_length = cfg_data;
          CFG_DECRYPT_MODE: decrypting = cfg_data[0];
          default: ;
        endcase
      end
      if (res_valid && !res_stall) begin
        if (cipher_q.size() == 0) begin
          flag_error("unexpected result", res_data.out_byte, 8'd0);
        end else begin
          want = cipher_q.pop_front();
          if (res_data.out_byte !== want.out_byte)
            flag_error("out_byte", res_data.out_byte, want.out_byte);
          if (res_data.was_letter !== want.was_letter)
            flag_error("was_letter", {7'd0, res_data.was_letter}, {7'd0, want.was_letter});
        end
      end
      if (req_valid && !req_stall) begin
        case (req_data.op)
          OP_LOAD: begin
            if (req_data.key_slot < KEY_DEPTH)
              shift_table[req_data.key_slot] = shift_of(req_data.data_byte);
          end
          OP_RESTART: key_pos = 0;
          OP_CIPHER:  cipher_q.push_back(encipher(req_data.data_byte));
          default: ;
        endcase
      end
    end
    pending = cipher_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import cvc_pkg::*;

  localparam int         KEY_DEPTH   = 64;
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         PHASES      = 10;
  localparam int         PHASE_ITEMS = 25;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  req_t                   req_data = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  res_t                   res_data;
  logic                   cfg_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int unsigned            fails;
  int unsigned            pending;

  bit          key_written [KEY_DEPTH];
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  // long key followed by a short one leaves the position past the end
  int unsigned phase_len  [PHASES] = '{1, 7, 2047, 3, 0, 1024, 2, 33, 5, 16};
  bit          phase_dec  [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 0, 1, 1};
  int unsigned phase_zero [PHASES] = '{10, 30, 20, 40, 0, 25, 100, 50, 60, 15};

  cyrillic_vigenere_cipher_core #(
    .KEY_DEPTH(KEY_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  cvc_tb_checker #(
    .KEY_DEPTH(KEY_DEPTH)
  ) u_checker (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data),
    .cfg_en   (cfg_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver modes: free, light stall, heavy stall, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      2: res_stall <= ($urandom_range(0, 3) != 0);
      default: res_stall <= (stall_left[1:0] == 2'd0);
    endcase
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic logic [7:0] pick_key_byte(int unsigned zero_pct);
    if ($urandom_range(0, 99) < zero_pct) begin
      case ($urandom_range(0, 2))
        0: return 8'hC0;
        1: return 8'hE0;
        default: return 8'($urandom_range(0, 191));
      endcase
    end
    return ($urandom_range(0, 1) ? 8'd224 : 8'd192) + 8'($urandom_range(1, 31));
  endfunction

  task automatic send(logic [1:0] op, logic [9:0] slot, logic [7:0] b);
    req_t        r;
    logic        stalled;
    int unsigned gap;
    r.op = op;
    r.key_slot = slot;
    r.data_byte = b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_data <= r;
    do begin
      @(negedge clk);
      stalled = req_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic load_key(logic [9:0] slot, logic [7:0] b);
    send(OP_LOAD, slot, b);
    key_written[slot] = 1'b1;
  endtask

  task automatic cipher(logic [7:0] b);
    send(OP_CIPHER, 10'($urandom), b);
  endtask

  // hold requests until every result is back and the core has settled
  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [CFG_DATA_W-1:0] len, logic dec);
    drain();
    write_reg(CFG_KEY_LENGTH, len);
    write_reg(CFG_DECRYPT_MODE, {{(CFG_DATA_W-1){1'b0}}, dec});
  endtask

  initial begin
    int unsigned eff;
    int unsigned done;
    int unsigned sel;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mode(11'd1, 1'b0);
    load_key(10'd0, 8'hC3);
    cipher(8'h00);
    cipher(8'hBF);
    cipher(8'hC0);
    cipher(8'hDF);
    cipher(8'hE0);
    cipher(8'hFF);
    cipher(8'h7F);
    send(OP_UNUSED, 10'h3FF, 8'hFF);
    send(OP_RESTART, 10'h155, 8'hAA);
    // non-Cyrillic key byte: zero shift everywhere, letter still flagged
    load_key(10'd0, 8'h41);
    cipher(8'hC5);
    load_key(10'd0, 8'hFF);
    cipher(8'hE1);
    // zero length clamps to one
    set_mode(11'd0, 1'b1);
    cipher(8'hC0);
    cipher(8'hFF);
    cipher(8'hE0);

    for (int p = 0; p < PHASES; p++) begin
      set_mode(CFG_DATA_W'(phase_len[p]), phase_dec[p]);
      if (phase_len[p] == 0) eff = 1;
      else if (phase_len[p] > KEY_DEPTH) eff = KEY_DEPTH;
      else eff = phase_len[p];
      for (int s = 0; s < eff; s++) begin
        if (!key_written[s] || eff <= 64) load_key(10'(s), pick_key_byte(phase_zero[p]));
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        if (done == PHASE_ITEMS / 2) drain();
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          load_key(10'(($urandom_range(0, 9) < 7) ? $urandom_range(0, eff - 1)
                                                  : $urandom_range(0, KEY_DEPTH - 1)),
                   pick_key_byte(phase_zero[p]));
          done++;
        end else if (sel < 17) begin
          send(OP_RESTART, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
          done++;
        end else if (sel < 20) begin
          send(OP_UNUSED, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
        end else begin
          cipher(8'(($urandom_range(0, 3) != 0) ? $urandom_range(192, 255)
                                                : $urandom_range(0, 255)));
          done++;
        end
      end
    end

    drain();
    if (fails == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/cvc_pkg.sv
rtl/core/cvc_key_mem.sv
rtl/core/cvc_mod_unit.sv
rtl/core/cyrillic_vigenere_cipher_core.sv
rtl/core/cvc_checker.sv
tb/cvc_checker.sv
tb/tb.sv
